FILE: rtl/vfcm_pkg.sv
// Shared types, codes and helpers of the voxel face culling mesher.
// Used by the front, back and top-level modules; depends on nothing.
`timescale 1ns / 1ps

package vfcm_pkg;

	// field and port widths
	localparam int COORD_W    = 5;
	localparam int MAT_W      = 8;
	localparam int VTX_W      = 20;
	localparam int SIDE_W     = 3;
	localparam int NUM_SIDES  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [VTX_W-1:0]      VTX_STEP   = VTX_W'(4);
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = CFG_DATA_W'(32);

	// input item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_MESH  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = CFG_IDX_W'(2);

	// face sides, in emission order
	localparam logic [SIDE_W-1:0] SIDE_TOP   = SIDE_W'(0);
	localparam logic [SIDE_W-1:0] SIDE_RIGHT = SIDE_W'(1);
	localparam logic [SIDE_W-1:0] SIDE_FRONT = SIDE_W'(2);
	localparam logic [SIDE_W-1:0] SIDE_LEFT  = SIDE_W'(3);
	localparam logic [SIDE_W-1:0] SIDE_BACK  = SIDE_W'(4);

	// read steps of a mesh job: center voxel, then one neighbor per side
	localparam logic [SIDE_W-1:0] STEP_CENTER = SIDE_W'(0);
	localparam logic [SIDE_W-1:0] STEP_LAST   = SIDE_W'(NUM_SIDES);

	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] pos_z;
		logic [MAT_W-1:0]   material_in;
	} cmd_t;

	typedef struct packed {
		logic [SIDE_W-1:0]  face_side;
		logic [COORD_W-1:0] face_x;
		logic [COORD_W-1:0] face_y;
		logic [COORD_W-1:0] face_z;
		logic [MAT_W-1:0]   material_out;
		logic [VTX_W-1:0]   first_vertex;
		logic               last_face;
	} face_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_MESH,
		OP_START
	} job_op_t;

	// classified item; bound marks sides on the grid edge
	typedef struct packed {
		job_op_t              op;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   z;
		logic [MAT_W-1:0]     material;
		logic [NUM_SIDES-1:0] bound;
	} job_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_READ,
		BS_DRAIN,
		BS_EMIT
	} back_state_t;

	// coordinate below both the size register and the grid dimension
	function automatic logic in_range(input logic [COORD_W-1:0] c,
			input logic [CFG_DATA_W-1:0] lim, input int unsigned dim);
		return ({1'b0, c} < lim) && (32'(c) < dim);
	endfunction

	// last coordinate in use; valid only for a coordinate in range
	function automatic logic at_far(input logic [COORD_W-1:0] c,
			input logic [CFG_DATA_W-1:0] lim, input int unsigned dim);
		return (({1'b0, c} + CFG_DATA_W'(1)) == lim) || ((32'(c) + 32'd1) == dim);
	endfunction

endpackage

FILE: rtl/vfcm_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type comes from the instance.
`timescale 1ns / 1ps

interface vfcm_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/voxel_face_culling_mesher_top.sv
// Top level of the voxel face culling mesher: size registers, front and back.
// Depends on vfcm_pkg, vfcm_stream_if, vfcm_front, vfcm_back and vfcm_ram.
`timescale 1ns / 1ps

// Usage:
// cmd carries items: write a voxel, mesh a voxel, or start a new mesh (clears
// the vertex counter). face carries one item per exposed face of a meshed
// voxel, in the order top, right, front, left, back; last_face marks the end.
// The size registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the block is idle (not enforced by the block).
// Every voxel of the grid in use must be written before meshing. Items pass
// through a four-entry queue into the back part. A write or start item is
// done in the idle state. A mesh item reads the voxel and its five neighbors
// through the single read port of the voxel memory, passes a drain state and
// emits one face per cycle while face is not stalled, none if none is exposed.
// Reset sets all sizes to 32, clears the vertex counter and empties the queue;
// voxel memory contents are undefined until written.
// When face is stalled, the output register holds its face, the back part
// waits, the queue fills and cmd.ready drops once four jobs are waiting.
module voxel_face_culling_mesher_top #(
	parameter int MAX_DIM = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vfcm_stream_if.sink                     cmd,
	vfcm_stream_if.source                   face,
	input  logic                            cfg_we,
	input  logic [vfcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vfcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import vfcm_pkg::*;

	logic [CFG_DATA_W-1:0] size_x_q;
	logic [CFG_DATA_W-1:0] size_y_q;
	logic [CFG_DATA_W-1:0] size_z_q;
	logic                  job_vld;
	job_t                  job;
	logic                  job_pop;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_wdata;
				REG_SIZE_Y: size_y_q <= cfg_wdata;
				REG_SIZE_Z: size_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	vfcm_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.size_x  (size_x_q),
		.size_y  (size_y_q),
		.size_z  (size_z_q),
		.job_vld (job_vld),
		.job     (job),
		.job_pop (job_pop)
	);

	vfcm_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_vld (job_vld),
		.job     (job),
		.job_pop (job_pop),
		.face    (face)
	);
endmodule

FILE: rtl/vfcm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module vfcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: rtl/vfcm_front.sv
// Front part: accepts input items, checks them against the grid and queues jobs.
// Depends on vfcm_pkg and vfcm_stream_if.
`timescale 1ns / 1ps

module vfcm_front #(
	parameter int MAX_DIM = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	vfcm_stream_if.sink                      cmd,
	input  logic [vfcm_pkg::CFG_DATA_W-1:0]  size_x,
	input  logic [vfcm_pkg::CFG_DATA_W-1:0]  size_y,
	input  logic [vfcm_pkg::CFG_DATA_W-1:0]  size_z,
	output logic                             job_vld,
	output vfcm_pkg::job_t                   job,
	input  logic                             job_pop
);
	import vfcm_pkg::*;

	cmd_t           c;
	logic           in_grid;
	logic           keep;
	logic           push;
	logic           full;
	job_t           job_new;
	job_t           fifo_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign c = cmd.data;

	// classify the item and mark the grid edges it touches
	always_comb begin
		in_grid = in_range(c.pos_x, size_x, MAX_DIM) && in_range(c.pos_y, size_y, MAX_DIM)
			&& in_range(c.pos_z, size_z, MAX_DIM);
		job_new.x        = c.pos_x;
		job_new.y        = c.pos_y;
		job_new.z        = c.pos_z;
		job_new.material = c.material_in;
		job_new.bound[SIDE_TOP]   = at_far(c.pos_y, size_y, MAX_DIM);
		job_new.bound[SIDE_RIGHT] = at_far(c.pos_x, size_x, MAX_DIM);
		job_new.bound[SIDE_FRONT] = at_far(c.pos_z, size_z, MAX_DIM);
		job_new.bound[SIDE_LEFT]  = (c.pos_x == '0);
		job_new.bound[SIDE_BACK]  = (c.pos_z == '0);
		case (c.kind)
			KIND_WRITE: begin
				job_new.op = OP_WRITE;
				keep       = in_grid;
			end
			KIND_MESH: begin
				job_new.op = OP_MESH;
				keep       = in_grid;
			end
			KIND_START: begin
				job_new.op = OP_START;
				keep       = 1'b1;
			end
			default: begin
				job_new.op = OP_START;
				keep       = 1'b0;
			end
		endcase
	end

	// drop items that change nothing, queue the rest
	assign full      = (count_q == (QAW+1)'(QDEPTH));
	assign cmd.ready = !full;
	assign push      = cmd.valid && !full && keep;
	assign job_vld   = (count_q != '0);
	assign job       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (job_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + (QAW+1)'(push) - (QAW+1)'(job_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= job_new;
		end
	end
endmodule

FILE: rtl/vfcm_back.sv
// Back part: runs queued jobs against the voxel memory and emits faces.
// Depends on vfcm_pkg, vfcm_stream_if and vfcm_ram.
`timescale 1ns / 1ps

module vfcm_back #(
	parameter int MAX_DIM = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_vld,
	input  vfcm_pkg::job_t job,
	output logic           job_pop,
	vfcm_stream_if.source  face
);
	import vfcm_pkg::*;

	localparam int AW = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);

	back_state_t          state_q;
	back_state_t          state_d;
	job_t                 job_q;
	logic [SIDE_W-1:0]    step_q;
	logic [SIDE_W-1:0]    rd_step_s1;
	logic                 rd_vld_s1;
	logic [MAT_W-1:0]     mat_q;
	logic [NUM_SIDES-1:0] pend_q;
	logic [VTX_W-1:0]     cnt_q;
	face_t                face_q;
	logic                 face_vld_q;

	logic                 ram_we;
	logic                 ram_re;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic [MAT_W-1:0]     rdata;
	logic                 load_job;
	logic                 cnt_clr;
	logic                 face_load;
	logic                 out_free;
	logic [NUM_SIDES-1:0] live;
	logic [SIDE_W-1:0]    pick;
	logic                 more;
	logic [SIDE_W-1:0]    rd_side;
	logic [SIDE_W-1:0]    cap_side;
	logic [COORD_W:0]     nx;
	logic [COORD_W:0]     ny;
	logic [COORD_W:0]     nz;

	function automatic logic [AW-1:0] vox_addr(input logic [COORD_W:0] x,
			input logic [COORD_W:0] y, input logic [COORD_W:0] z);
		return AW'((AW'(y) * AW'(MAX_DIM) + AW'(z)) * AW'(MAX_DIM) + AW'(x));
	endfunction

	vfcm_ram #(
		.WIDTH (MAT_W),
		.DEPTH (MAX_DIM * MAX_DIM * MAX_DIM)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (job.material),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign waddr = vox_addr({1'b0, job.x}, {1'b0, job.y}, {1'b0, job.z});

	// neighbor coordinates for the current read step
	assign rd_side = step_q - SIDE_W'(1);
	always_comb begin
		nx = {1'b0, job_q.x};
		ny = {1'b0, job_q.y};
		nz = {1'b0, job_q.z};
		case (rd_side)
			SIDE_TOP:   ny = {1'b0, job_q.y} + (COORD_W+1)'(1);
			SIDE_RIGHT: nx = {1'b0, job_q.x} + (COORD_W+1)'(1);
			SIDE_FRONT: nz = {1'b0, job_q.z} + (COORD_W+1)'(1);
			SIDE_LEFT:  nx = {1'b0, job_q.x} - (COORD_W+1)'(1);
			SIDE_BACK:  nz = {1'b0, job_q.z} - (COORD_W+1)'(1);
			default: ;
		endcase
	end

	// pick the first exposed face still to send
	assign live = (mat_q != '0) ? pend_q : '0;
	always_comb begin
		pick = '0;
		for (int i = NUM_SIDES - 1; i >= 0; i--) begin
			if (live[i]) begin
				pick = SIDE_W'(i);
			end
		end
		more = |(live & ~(NUM_SIDES'(1) << pick));
	end

	assign out_free = !face_vld_q || face.ready;

	// sequencer: next state and control
	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		raddr     = vox_addr(nx, ny, nz);
		load_job  = 1'b0;
		cnt_clr   = 1'b0;
		face_load = 1'b0;
		case (state_q)
			BS_IDLE: begin
				if (job_vld) begin
					job_pop = 1'b1;
					case (job.op)
						OP_WRITE: ram_we = 1'b1;
						OP_START: cnt_clr = 1'b1;
						OP_MESH: begin
							ram_re   = 1'b1;
							raddr    = vox_addr({1'b0, job.x}, {1'b0, job.y},
								{1'b0, job.z});
							load_job = 1'b1;
							state_d  = BS_READ;
						end
						default: ;
					endcase
				end
			end
			BS_READ: begin
				ram_re = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = BS_DRAIN;
				end
			end
			BS_DRAIN: state_d = BS_EMIT;
			BS_EMIT: begin
				if (live == '0) begin
					state_d = BS_IDLE;
				end else if (out_free) begin
					face_load = 1'b1;
					if (!more) begin
						state_d = BS_IDLE;
					end
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: read tracking, vertex counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			cnt_q      <= '0;
			face_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (face_load) begin
				cnt_q <= cnt_q + VTX_STEP;
			end
			if (face_load) begin
				face_vld_q <= 1'b1;
			end else if (face.ready) begin
				face_vld_q <= 1'b0;
			end
		end
	end

	assign cap_side = rd_step_s1 - SIDE_W'(1);

	// job data, read results and the output item
	always_ff @(posedge clk) begin
		if (load_job) begin
			job_q  <= job;
			step_q <= STEP_CENTER + SIDE_W'(1);
		end else if (state_q == BS_READ) begin
			step_q <= step_q + SIDE_W'(1);
		end
		rd_step_s1 <= load_job ? STEP_CENTER : step_q;
		if (rd_vld_s1) begin
			if (rd_step_s1 == STEP_CENTER) begin
				mat_q <= rdata;
			end else begin
				pend_q[cap_side] <= job_q.bound[cap_side] || (rdata == '0);
			end
		end
		if (face_load) begin
			pend_q[pick]        <= 1'b0;
			face_q.face_side    <= pick;
			face_q.face_x       <= job_q.x;
			face_q.face_y       <= job_q.y;
			face_q.face_z       <= job_q.z;
			face_q.material_out <= mat_q;
			face_q.first_vertex <= cnt_q;
			face_q.last_face    <= !more;
		end
	end

	assign face.valid = face_vld_q;
	assign face.data  = face_q;
endmodule
